// ===== rtl/css_pkg.sv =====
// Package: character codes, totals layout and defaults for the CIGAR statistics block.
`default_nettype none
package css_pkg;

    localparam int DEFAULT_COUNT_WIDTH = 32;
    localparam int OUT_WIDTH           = 32;
    localparam int CHAR_WIDTH          = 8;

    localparam logic [CHAR_WIDTH-1:0] CH_0  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_9  = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_M  = 8'h4D;
    localparam logic [CHAR_WIDTH-1:0] CH_I  = 8'h49;
    localparam logic [CHAR_WIDTH-1:0] CH_D  = 8'h44;
    localparam logic [CHAR_WIDTH-1:0] CH_N  = 8'h4E;
    localparam logic [CHAR_WIDTH-1:0] CH_S  = 8'h53;
    localparam logic [CHAR_WIDTH-1:0] CH_H  = 8'h48;
    localparam logic [CHAR_WIDTH-1:0] CH_P  = 8'h50;
    localparam logic [CHAR_WIDTH-1:0] CH_X  = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CH_EQ = 8'h3D;

    localparam int N_TOT      = 8;
    localparam int TOT_MIS    = 0;
    localparam int TOT_MAT    = 1;
    localparam int TOT_DEL    = 2;
    localparam int TOT_INS    = 3;
    localparam int TOT_INSLEN = 4;
    localparam int TOT_SOFT   = 5;
    localparam int TOT_HARD   = 6;
    localparam int TOT_SPAN   = 7;

    localparam int N_OUT = 8;

endpackage
`default_nettype wire

// ===== rtl/css_accum.sv =====
// Run-length parser and saturating per-string totals.
`default_nettype none
module css_accum
    import css_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic [CHAR_WIDTH-1:0]                 i_char,
    input  wire logic                                  i_last,
    output logic      [N_TOT-1:0][COUNT_WIDTH-1:0]     o_tot
);

    localparam int W = COUNT_WIDTH;

    logic [W-1:0]              r_run;
    logic [W-1:0]              n_run;
    logic [N_TOT-1:0][W-1:0]   r_tot;
    logic [N_TOT-1:0][W-1:0]   n_tot;
    logic [W+3:0]              run_x10;
    logic [3:0]                digit;
    logic                      is_digit;
    logic                      is_op;

    function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[W] ? {W{1'b1}} : s[W-1:0];
    endfunction

    assign is_digit = (i_char >= CH_0) && (i_char <= CH_9);
    assign is_op    = (i_char == CH_M) || (i_char == CH_I) || (i_char == CH_D) ||
                      (i_char == CH_N) || (i_char == CH_S) || (i_char == CH_H) ||
                      (i_char == CH_P) || (i_char == CH_X) || (i_char == CH_EQ);
    assign digit    = 4'(i_char - CH_0);
    assign run_x10  = {1'b0, r_run, 3'b000} + {3'b000, r_run, 1'b0} + (W+4)'(digit);

    always_comb begin
        n_run = r_run;
        n_tot = r_tot;
        if (is_digit) begin
            n_run = (run_x10[W+3:W] != 4'd0) ? {W{1'b1}} : run_x10[W-1:0];
        end else if (is_op) begin
            n_run = '0;
            if ((i_char == CH_M) || (i_char == CH_D) || (i_char == CH_N) ||
                (i_char == CH_X) || (i_char == CH_EQ)) begin
                n_tot[TOT_SPAN] = sat_add(r_tot[TOT_SPAN], r_run);
            end
            if (i_char == CH_X) begin
                n_tot[TOT_MIS] = sat_add(r_tot[TOT_MIS], r_run);
            end
            if (i_char == CH_EQ) begin
                n_tot[TOT_MAT] = sat_add(r_tot[TOT_MAT], r_run);
            end
            if (i_char == CH_D) begin
                n_tot[TOT_DEL] = sat_add(r_tot[TOT_DEL], W'(1));
            end
            if (i_char == CH_I) begin
                n_tot[TOT_INS]    = sat_add(r_tot[TOT_INS], W'(1));
                n_tot[TOT_INSLEN] = sat_add(r_tot[TOT_INSLEN], r_run);
            end
            if (i_char == CH_S) begin
                n_tot[TOT_SOFT] = sat_add(r_tot[TOT_SOFT], r_run);
            end
            if (i_char == CH_H) begin
                n_tot[TOT_HARD] = sat_add(r_tot[TOT_HARD], r_run);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
            r_tot <= '0;
        end else if (i_en) begin
            if (i_last) begin
                r_run <= '0;
                r_tot <= '0;
            end else begin
                r_run <= n_run;
                r_tot <= n_tot;
            end
        end
    end

    assign o_tot = n_tot;

endmodule
`default_nettype wire

// ===== rtl/cigar_string_statistics.sv =====
// Top level of the CIGAR string statistics block: stream ports, pipeline and result register.
`default_nettype none
// Takes one CIGAR character per cycle and, on the character marked tlast, emits one
// 256-bit result with the string's totals; the next string may start in the very next
// cycle. A character passes an input register, then the parser updates its totals;
// on the last character the totals are captured, and from them the saturating
// query length is formed into the output register. Throughput is one character per
// cycle, limited only by downstream tready.
// All totals saturate at 2**COUNT_WIDTH-1; each output field carries its low 32 bits.
module cigar_string_statistics
    import css_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire logic [7:0]                 i_s_axis_tdata,  // [7:0] char_code
    input  wire logic                       i_s_axis_tlast,  // last_char
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    // [31:0] query_length, [63:32] mismatch_length, [95:64] match_length,
    // [127:96] deletion_events, [159:128] insertion_events, [191:160] soft_clip_length,
    // [223:192] hard_clip_length, [255:224] reference_span
    output logic [N_OUT*OUT_WIDTH-1:0]      o_m_axis_tdata
);

    localparam int W = COUNT_WIDTH;

    logic                          r_in_valid;
    logic [CHAR_WIDTH-1:0]         r_in_char;
    logic                          r_in_last;
    logic                          r_tot_valid;
    logic [N_TOT-1:0][W-1:0]       r_tot;
    logic                          r_out_valid;
    logic [N_OUT-1:0][OUT_WIDTH-1:0] r_out;
    logic [N_OUT-1:0][OUT_WIDTH-1:0] n_out;
    logic [N_TOT-1:0][W-1:0]       acc_tot;
    logic [W+2:0]                  q_sum;
    logic [W-1:0]                  q_sat;
    logic                          out_free;
    logic                          tot_free;
    logic                          tot_adv;
    logic                          in_adv;

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign tot_adv  = r_tot_valid && out_free;
    assign tot_free = !r_tot_valid || out_free;
    assign in_adv   = r_in_valid && (!r_in_last || tot_free);
    assign o_s_axis_tready = !r_in_valid || in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_char <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    css_accum #(
        .COUNT_WIDTH (W)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_adv),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_tot   (acc_tot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot_valid <= 1'b0;
        end else if (tot_free) begin
            r_tot_valid <= in_adv && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tot_free && in_adv && r_in_last) begin
            r_tot <= acc_tot;
        end
    end

    assign q_sum = (W+3)'(r_tot[TOT_MIS]) + (W+3)'(r_tot[TOT_MAT]) +
                   (W+3)'(r_tot[TOT_INSLEN]) + (W+3)'(r_tot[TOT_SOFT]) +
                   (W+3)'(r_tot[TOT_HARD]);
    assign q_sat = (q_sum[W+2:W] != 3'd0) ? {W{1'b1}} : q_sum[W-1:0];

    always_comb begin
        n_out[0] = OUT_WIDTH'(q_sat);
        n_out[1] = OUT_WIDTH'(r_tot[TOT_MIS]);
        n_out[2] = OUT_WIDTH'(r_tot[TOT_MAT]);
        n_out[3] = OUT_WIDTH'(r_tot[TOT_DEL]);
        n_out[4] = OUT_WIDTH'(r_tot[TOT_INS]);
        n_out[5] = OUT_WIDTH'(r_tot[TOT_SOFT]);
        n_out[6] = OUT_WIDTH'(r_tot[TOT_HARD]);
        n_out[7] = OUT_WIDTH'(r_tot[TOT_SPAN]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_tot_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tot_adv) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    a_last_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_adv && r_in_last) |=> r_tot_valid)
        else $error("last character did not load the totals stage");

    a_tot_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tot_valid && !out_free) |=> (r_tot_valid && $stable(r_tot)))
        else $error("stalled totals changed");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tot_adv |=> o_m_axis_tvalid)
        else $error("totals moved without an output result");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && !in_adv) |=> (r_in_valid && r_in_last))
        else $error("blocked last character was dropped");

endmodule
`default_nettype wire
